FILE: sv/pett_pkg.sv
// ----------------------------------------------------------------------------
// pett_pkg: shared types, constants and helpers of the phased event timer table
// Entry layout, command and status codes, and the saturating timer arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

package pett_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CAPACITY);

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] timer;
    logic [7:0]  phase;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    CMD_CLEAR     = 3'd0,
    CMD_TICK      = 3'd1,
    CMD_ADD       = 3'd2,
    CMD_REMOVE    = 3'd3,
    CMD_POP       = 3'd4,
    CMD_DELAY_ONE = 3'd5,
    CMD_DELAY_ALL = 3'd6
  } cmd_t;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Adds a delay to a timer, sticking at the all-ones maximum.
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Counts a timer down by the elapsed time, stopping at zero.
  function automatic logic [31:0] sub_floor(input logic [31:0] a, input logic [31:0] b);
    return (a > b) ? (a - b) : 32'd0;
  endfunction

endpackage

`default_nettype wire

FILE: sv/phased_event_timer_table_core.sv
// ----------------------------------------------------------------------------
// phased_event_timer_table_core: table of phased countdown timers
// Command-driven timer table held in one entry memory with valid flags.
// ----------------------------------------------------------------------------
// The block keeps up to CAPACITY countdown timers, each with a 32-bit event id
// and an 8-bit phase (phase 0 matches every phase). One command word goes in,
// one result word comes out. Every command except clear and the unused codes
// walks the entry memory once, one entry per cycle over its single read port;
// clear and unused codes skip the walk and go straight to the finishing state.
// The result sits in an output register, so the next command is taken while
// an earlier result still waits for the sink. Valid flags live in flip-flops
// and are cleared by reset and by the clear command; the entry memory needs no
// clearing pass because an entry is only ever looked at while its flag is set.
// ----------------------------------------------------------------------------
`default_nettype none

module phased_event_timer_table_core
  import pett_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // [31:0] event_id, [63:32] amount, [71:64] phase
  input  wire logic [2:0]  in_tuser,   // [2:0] command
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata   // [1:0] status, [33:2] finished_id, [39:34] zero
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Command word captured at accept.
  logic [2:0]  cmd_r, cmd_nxt;
  logic [31:0] id_r, id_nxt;
  logic [31:0] amt_r, amt_nxt;
  logic [7:0]  ph_r, ph_nxt;

  logic [7:0]          cur_phase_r, cur_phase_nxt;
  logic [CAPACITY-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  // Scan bookkeeping: matching (or best expired) entry and the lowest free slot.
  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  entry_t           hit_ent_r, hit_ent_nxt;
  logic             free_r, free_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic [31:0] out_fin_r, out_fin_nxt;

  // Entry memory ports.
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  entry_t           rd_ent;
  logic [CNT_W-1:0] cnt_m1;
  logic [IDX_W-1:0] pidx;
  logic             proc;
  logic             pvalid;
  logic             ph_cur_hit;
  logic             ph_cmd_hit;
  logic             fin_go;
  logic             accept;

  pett_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_fin_r, out_status_r};

  // The read for entry k is issued at count k; its data is processed at k + 1.
  assign ram_raddr  = cnt_r[IDX_W-1:0];
  assign cnt_m1     = cnt_r - 1'b1;
  assign pidx       = cnt_m1[IDX_W-1:0];
  assign proc       = (state_r == S_SCAN) && (cnt_r != '0);
  assign rd_ent     = entry_t'(ram_rdata);
  assign pvalid     = valid_r[pidx];
  assign ph_cur_hit = (rd_ent.phase == 8'd0) || (rd_ent.phase == cur_phase_r);
  assign ph_cmd_hit = (rd_ent.phase == 8'd0) || (rd_ent.phase == ph_r);
  assign fin_go     = (state_r == S_FIN) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    id_nxt         = id_r;
    amt_nxt        = amt_r;
    ph_nxt         = ph_r;
    cur_phase_nxt  = cur_phase_r;
    valid_nxt      = valid_r;
    cnt_nxt        = cnt_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_ent_nxt    = hit_ent_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_fin_nxt    = out_fin_r;
    ram_we         = 1'b0;
    ram_waddr      = pidx;
    ram_wdata      = rd_ent;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt  = in_tuser;
          id_nxt   = in_tdata[31:0];
          amt_nxt  = in_tdata[63:32];
          ph_nxt   = in_tdata[71:64];
          cnt_nxt  = '0;
          hit_nxt  = 1'b0;
          free_nxt = 1'b0;
          if (in_tuser == CMD_TICK) begin
            cur_phase_nxt = in_tdata[71:64];
          end
          if (in_tuser inside {CMD_TICK, CMD_ADD, CMD_REMOVE, CMD_POP,
                               CMD_DELAY_ONE, CMD_DELAY_ALL}) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end

      S_SCAN: begin
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (proc) begin
          case (cmd_r)
            CMD_TICK: begin
              if (pvalid && ph_cur_hit) begin
                ram_we          = 1'b1;
                ram_wdata.timer = sub_floor(rd_ent.timer, amt_r);
              end
            end
            CMD_DELAY_ALL: begin
              if (pvalid && (rd_ent.timer != 32'd0) && ph_cmd_hit) begin
                ram_we          = 1'b1;
                ram_wdata.timer = sat_add(rd_ent.timer, amt_r);
              end
            end
            CMD_POP: begin
              if (pvalid && (rd_ent.timer == 32'd0) && ph_cur_hit &&
                  (!hit_r || (rd_ent.id < hit_ent_r.id))) begin
                hit_nxt     = 1'b1;
                hit_idx_nxt = pidx;
                hit_ent_nxt = rd_ent;
              end
            end
            CMD_ADD, CMD_REMOVE, CMD_DELAY_ONE: begin
              // Ids are unique in the table, so the first match is the only one.
              if (pvalid && (rd_ent.id == id_r) && !hit_r) begin
                hit_nxt     = 1'b1;
                hit_idx_nxt = pidx;
                hit_ent_nxt = rd_ent;
              end
              if (!pvalid && !free_r) begin
                free_nxt     = 1'b1;
                free_idx_nxt = pidx;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_FIN: begin
        if (fin_go) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_DONE;
          out_fin_nxt    = 32'd0;
          case (cmd_r)
            CMD_CLEAR: begin
              valid_nxt     = '0;
              cur_phase_nxt = 8'd0;
            end
            CMD_ADD: begin
              ram_wdata.id    = id_r;
              ram_wdata.timer = amt_r;
              ram_wdata.phase = ph_r;
              if (hit_r) begin
                ram_we               = 1'b1;
                ram_waddr            = hit_idx_r;
                valid_nxt[hit_idx_r] = 1'b1;
              end else if (free_r) begin
                ram_we                = 1'b1;
                ram_waddr             = free_idx_r;
                valid_nxt[free_idx_r] = 1'b1;
              end else begin
                out_status_nxt = ST_FULL;
              end
            end
            CMD_REMOVE: begin
              if (hit_r) begin
                valid_nxt[hit_idx_r] = 1'b0;
              end else begin
                out_status_nxt = ST_MISS;
              end
            end
            CMD_POP: begin
              if (hit_r) begin
                valid_nxt[hit_idx_r] = 1'b0;
                out_fin_nxt          = hit_ent_r.id;
              end else begin
                out_status_nxt = ST_MISS;
              end
            end
            CMD_DELAY_ONE: begin
              if (hit_r && (hit_ent_r.timer != 32'd0)) begin
                ram_we          = 1'b1;
                ram_waddr       = hit_idx_r;
                ram_wdata       = hit_ent_r;
                ram_wdata.timer = sat_add(hit_ent_r.timer, amt_r);
              end else begin
                out_status_nxt = ST_MISS;
              end
            end
            default: begin
            end
          endcase
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_phase_r <= 8'd0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_phase_r <= cur_phase_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      hit_r       <= hit_nxt;
      free_r      <= free_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    id_r         <= id_nxt;
    amt_r        <= amt_nxt;
    ph_r         <= ph_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_ent_r    <= hit_ent_nxt;
    free_idx_r   <= free_idx_nxt;
    out_status_r <= out_status_nxt;
    out_fin_r    <= out_fin_nxt;
  end

  // The entry memory is only written while a command is being worked on.
  a_we_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_SCAN || state_r == S_FIN))
    else $error("entry memory written outside a command");

  // The scan counter never walks past the last entry.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (cnt_r <= CNT_LAST))
    else $error("scan counter out of range");

  // An accepted command always leaves the idle state on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_SCAN || state_r == S_FIN))
    else $error("accepted command did not start");

  // A successful pop frees the popped slot.
  a_pop_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && (cmd_r == CMD_POP) && hit_r) |=> !valid_r[$past(hit_idx_r)])
    else $error("popped entry still valid");

  // A command that finishes always produces a result.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |=> out_valid_r)
    else $error("finished command produced no result");

endmodule

`default_nettype wire

FILE: sv/pett_ram.sv
// ----------------------------------------------------------------------------
// pett_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pett_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: tb/tb_phased_event_timer_table_core.sv
// ----------------------------------------------------------------------------
// tb_phased_event_timer_table_core: self-checking bench of the timer table
// Drives command words into the block, predicts every result word with an
// independent model of the table, and compares status and finished id of
// each result in order, under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_phased_event_timer_table_core;
  import pett_pkg::*;

  // Code 3'd7 is not a command; the block must answer it with a plain done.
  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 2 * (CAPACITY + 3);

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] fin_id;
  } timer_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata   = '0;   // [31:0] event_id, [63:32] amount, [71:64] phase
  logic [2:0]  in_tuser   = '0;   // [2:0] command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // [1:0] status, [33:2] finished_id, [39:34] zero

  phased_event_timer_table_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  // Shadow copy of the timer table.
  logic        tbl_valid [CAPACITY];
  logic [31:0] tbl_id    [CAPACITY];
  logic [31:0] tbl_timer [CAPACITY];
  logic [7:0]  tbl_phase [CAPACITY];
  logic [7:0]  cur_phase;

  timer_result_t expected_q[$];

  bit src_gaps_on    = 1'b1;
  bit sink_stalls_on = 1'b1;
  int errors         = 0;
  int n_sent         = 0;
  int n_checked      = 0;
  int n_popped       = 0;
  int n_miss         = 0;
  int n_full         = 0;
  int quiet_cycles   = 0;
  int ready_hold     = 0;

  function automatic bit phase_hits(int slot, logic [7:0] ph);
    return (tbl_phase[slot] == 8'd0) || (tbl_phase[slot] == ph);
  endfunction

  function automatic int slot_of_id(logic [31:0] id);
    for (int i = 0; i < CAPACITY; i++) begin
      if (tbl_valid[i] && tbl_id[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic logic [31:0] add_capped(logic [31:0] a, logic [31:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  // Applies one command to the shadow table and returns the result it causes.
  task automatic timer_table_step(input logic [2:0] cmd, input logic [31:0] id,
                                  input logic [31:0] amt, input logic [7:0] ph,
                                  output timer_result_t res);
    int slot;
    res.status = ST_DONE;
    res.fin_id = '0;
    slot = -1;
    case (cmd)
      CMD_CLEAR: begin
        for (int i = 0; i < CAPACITY; i++) tbl_valid[i] = 1'b0;
        cur_phase = 8'd0;
      end
      CMD_TICK: begin
        cur_phase = ph;
        for (int i = 0; i < CAPACITY; i++) begin
          if (tbl_valid[i] && phase_hits(i, ph))
            tbl_timer[i] = (tbl_timer[i] > amt) ? tbl_timer[i] - amt : 32'd0;
        end
      end
      CMD_ADD: begin
        slot = slot_of_id(id);
        for (int i = 0; i < CAPACITY; i++) begin
          if (slot < 0 && !tbl_valid[i]) slot = i;
        end
        if (slot < 0) begin
          res.status = ST_FULL;
        end else begin
          tbl_valid[slot] = 1'b1;
          tbl_id[slot]    = id;
          tbl_timer[slot] = amt;
          tbl_phase[slot] = ph;
        end
      end
      CMD_REMOVE: begin
        slot = slot_of_id(id);
        if (slot < 0) res.status = ST_MISS;
        else tbl_valid[slot] = 1'b0;
      end
      CMD_POP: begin
        // Lowest id wins among expired entries of a matching phase.
        for (int i = 0; i < CAPACITY; i++) begin
          if (tbl_valid[i] && tbl_timer[i] == 32'd0 && phase_hits(i, cur_phase)) begin
            if (slot < 0 || tbl_id[i] < tbl_id[slot]) slot = i;
          end
        end
        if (slot < 0) begin
          res.status = ST_MISS;
        end else begin
          res.fin_id = tbl_id[slot];
          tbl_valid[slot] = 1'b0;
        end
      end
      CMD_DELAY_ONE: begin
        slot = slot_of_id(id);
        if (slot < 0 || tbl_timer[slot] == 32'd0) res.status = ST_MISS;
        else tbl_timer[slot] = add_capped(tbl_timer[slot], amt);
      end
      CMD_DELAY_ALL: begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (tbl_valid[i] && tbl_timer[i] != 32'd0 && phase_hits(i, ph))
            tbl_timer[i] = add_capped(tbl_timer[i], amt);
        end
      end
      default: begin
      end
    endcase
    if (res.status == ST_MISS) n_miss++;
    if (res.status == ST_FULL) n_full++;
    if (cmd == CMD_POP && res.status == ST_DONE) n_popped++;
  endtask

  // Offers one command word, waits for it to be taken, then records what
  // the table should answer and optionally leaves a gap on the bus.
  task automatic send_command(input logic [2:0] cmd, input logic [31:0] id,
                              input logic [31:0] amt, input logic [7:0] ph);
    timer_result_t res;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {ph, amt, id};
    do @(posedge clk); while (in_tready !== 1'b1);
    timer_table_step(cmd, id, amt, ph, res);
    expected_q.push_back(res);
    n_sent++;
    if (src_gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Ids come mostly from a small pool, half of it near the top of the range,
  // so adds, removes and delays hit existing entries and the table fills up.
  function automatic logic [31:0] pick_id();
    int k;
    k = $urandom_range(0, 23);
    if ($urandom_range(0, 9) == 0) return $urandom;
    return (k < 12) ? 32'(k) : ~32'(k - 12);
  endfunction

  function automatic logic [7:0] pick_phase();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 3));
  endfunction

  function automatic logic [31:0] pick_amount(int span);
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return 32'hFFFF_FFFF - 32'($urandom_range(0, span));
      default: return 32'($urandom_range(0, span));
    endcase
  endfunction

  task automatic send_random_command();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30)      send_command(CMD_ADD, pick_id(), pick_amount(40), pick_phase());
    else if (r < 50) send_command(CMD_TICK, $urandom, pick_amount(12), pick_phase());
    else if (r < 63) send_command(CMD_POP, $urandom, $urandom, 8'($urandom));
    else if (r < 73) send_command(CMD_REMOVE, pick_id(), $urandom, 8'($urandom));
    else if (r < 83) send_command(CMD_DELAY_ONE, pick_id(), pick_amount(20), 8'($urandom));
    else if (r < 94) send_command(CMD_DELAY_ALL, $urandom, pick_amount(20), pick_phase());
    else if (r < 97) send_command(CMD_CLEAR, $urandom, $urandom, 8'($urandom));
    else             send_command(CMD_UNUSED, $urandom, $urandom, 8'($urandom));
  endtask

  // Misses on an empty table, extreme ids and timers, replacement, capped
  // delays, phase filtering of ticks and pops, and the unused code.
  task automatic test_directed();
    send_command(CMD_CLEAR, 32'h0, 32'h0, 8'h00);
    send_command(CMD_POP, 32'h0, 32'h0, 8'h00);
    send_command(CMD_REMOVE, 32'd5, 32'h0, 8'h00);
    send_command(CMD_DELAY_ONE, 32'd5, 32'd1, 8'h00);
    send_command(CMD_ADD, 32'h0, 32'h0, 8'h00);
    send_command(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    send_command(CMD_ADD, 32'd7, 32'd10, 8'h01);
    send_command(CMD_ADD, 32'd7, 32'd3, 8'h02);
    send_command(CMD_DELAY_ALL, 32'h0, 32'd1, 8'hFF);
    send_command(CMD_DELAY_ONE, 32'hFFFF_FFFF, 32'd5, 8'h00);
    send_command(CMD_DELAY_ONE, 32'h0, 32'd5, 8'h00);
    send_command(CMD_TICK, 32'h0, 32'd0, 8'h02);
    send_command(CMD_POP, 32'h0, 32'h0, 8'h00);
    send_command(CMD_TICK, 32'h0, 32'd5, 8'h02);
    send_command(CMD_TICK, 32'h0, 32'hFFFF_FFFF, 8'h01);
    send_command(CMD_POP, 32'h0, 32'h0, 8'h00);
    send_command(CMD_TICK, 32'h0, 32'd0, 8'h02);
    send_command(CMD_POP, 32'h0, 32'h0, 8'h00);
    send_command(CMD_TICK, 32'h0, 32'hFFFF_FFFF, 8'hFF);
    send_command(CMD_DELAY_ALL, 32'h0, 32'd9, 8'hFF);
    send_command(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    send_command(CMD_ADD, 32'd3, 32'd0, 8'h04);
    send_command(CMD_ADD, 32'd1, 32'd0, 8'h00);
    send_command(CMD_POP, 32'h0, 32'h0, 8'h00);
    send_command(CMD_POP, 32'h0, 32'h0, 8'h00);
  endtask

  // Fills every slot, refuses a new id, still replaces an existing one, and
  // accepts a new id again once a slot is free.
  task automatic test_table_full();
    send_command(CMD_CLEAR, 32'h0, 32'h0, 8'h00);
    for (int i = 0; i < CAPACITY; i++)
      send_command(CMD_ADD, 32'd115 - 32'(i), 32'(i), 8'h00);
    send_command(CMD_ADD, 32'd200, 32'd1, 8'h00);
    send_command(CMD_ADD, 32'd105, 32'd0, 8'h00);
    send_command(CMD_REMOVE, 32'd103, 32'h0, 8'h00);
    send_command(CMD_ADD, 32'd200, 32'd0, 8'h00);
    send_command(CMD_POP, 32'h0, 32'h0, 8'h00);
    send_command(CMD_TICK, 32'h0, 32'hFFFF_FFFF, 8'h00);
    send_command(CMD_POP, 32'h0, 32'h0, 8'h00);
  endtask

  // Random traffic with idling on both sides; the source holds off now and
  // then until the table has answered everything.
  task automatic test_random_idling(input int count);
    for (int i = 0; i < count; i++) begin
      send_random_command();
      if (i % 300 == 299) wait_for_results();
    end
  endtask

  // Back-to-back random traffic with the sink always ready.
  task automatic test_random_streaming(input int count);
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    for (int i = 0; i < count; i++) send_random_command();
  endtask

  // Sink readiness with random stall bursts.
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_tready <= 1'b0;
    end else if (sink_stalls_on && $urandom_range(0, 7) == 0) begin
      ready_hold <= $urandom_range(0, 9);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_result
    timer_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_checked++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, actual status %0d id %h",
                 $time, out_tdata[1:0], out_tdata[33:2]);
      end else begin
        want = expected_q.pop_front();
        if (out_tdata[1:0] !== want.status) begin
          errors++;
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, out_tdata[1:0]);
        end
        if (out_tdata[33:2] !== want.fin_id) begin
          errors++;
          $display("%0t: finished_id mismatch, expected %h, actual %h",
                   $time, want.fin_id, out_tdata[33:2]);
        end
      end
    end
  end

  // Ends a hung run: too long without a word moving on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, expected_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < CAPACITY; i++) tbl_valid[i] = 1'b0;
    cur_phase = 8'd0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    wait_for_results();
    test_table_full();
    wait_for_results();
    test_random_idling(1200);
    wait_for_results();
    test_random_streaming(400);
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d commands and checked %0d results under idling and back to back.",
             n_sent, n_checked);
    $display("Pops returning an id: %0d, misses: %0d, full-table refusals: %0d.",
             n_popped, n_miss, n_full);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
sv/pett_pkg.sv
sv/pett_ram.sv
sv/phased_event_timer_table_core.sv
tb/tb_phased_event_timer_table_core.sv
